### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DGSP_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define DGSP_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

### design/dgsp_pkg.sv
// ---------------------------------------------------------------------------
// dgsp_pkg
// Sizes, types and shared structs of the dense-graph shortest path block.
// ---------------------------------------------------------------------------
package dgsp_pkg;

  localparam int N_VERTICES  = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int VERTEX_BITS = $clog2(N_VERTICES);
  localparam int ADDR_BITS   = 2 * VERTEX_BITS;
  localparam int RAM_DEPTH   = 2 ** ADDR_BITS;

  localparam int ID_BITS     = 4;
  localparam int EDGE_BITS   = 16;
  localparam int DIST_BITS   = 20;
  localparam int SUM_BITS    = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [DIST_BITS-1:0]   dist_t;
  typedef logic [SUM_BITS-1:0]    sum_t;

  localparam dist_t   DIST_MAX    = '1;
  localparam vertex_t VERTEX_LAST = vertex_t'(N_VERTICES - 1);
  localparam vertex_t ROUND_LAST  = vertex_t'(N_VERTICES - 2);

  typedef struct packed {
    logic    we;
    addr_t   waddr;
    weight_t wdata;
  } ram_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [ID_BITS-1:0]   vertex_id;
    logic [DIST_BITS-1:0] path_length;
    logic                 reachable;
    logic                 result_last;
  } result_t;

endpackage

### design/dgsp_if.sv
// ---------------------------------------------------------------------------
// dgsp channel interfaces
// Load channel for matrix entries and result channel for distances.
// ---------------------------------------------------------------------------
interface dgsp_load_if;
  logic                          valid;
  logic                          ready;
  logic [dgsp_pkg::ID_BITS-1:0]  row_vertex;
  logic [dgsp_pkg::ID_BITS-1:0]  col_vertex;
  logic [dgsp_pkg::EDGE_BITS-1:0] edge_weight;
  logic                          load_last;

  modport source (output valid, row_vertex, col_vertex, edge_weight, load_last,
                  input ready);
  modport sink (input valid, row_vertex, col_vertex, edge_weight, load_last,
                output ready);
endinterface

interface dgsp_result_if;
  logic                           valid;
  logic                           ready;
  logic [dgsp_pkg::ID_BITS-1:0]   vertex_id;
  logic [dgsp_pkg::DIST_BITS-1:0] path_length;
  logic                           reachable;
  logic                           result_last;

  modport source (output valid, vertex_id, path_length, reachable, result_last,
                  input ready);
  modport sink (input valid, vertex_id, path_length, reachable, result_last,
                output ready);
endinterface

### design/dgsp_weight_ram.sv
// ---------------------------------------------------------------------------
// dgsp_weight_ram
// Adjacency matrix store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module dgsp_weight_ram (
  input  logic              clk,
  input  dgsp_pkg::ram_wr_t wr,
  input  dgsp_pkg::addr_t   raddr,
  output dgsp_pkg::weight_t rdata
);

  dgsp_pkg::weight_t mem [dgsp_pkg::RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/dgsp_core.sv
// ---------------------------------------------------------------------------
// dgsp_core
// Search sequencer: scans for the next vertex, relaxes its row through one
// shared add/compare unit, then streams the distances out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dgsp_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dgsp_pkg::ID_BITS-1:0] source,
  output logic                       idle,
  output dgsp_pkg::addr_t            raddr,
  input  dgsp_pkg::weight_t          rdata,
  output dgsp_pkg::result_t          res,
  input  logic                       res_ready
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INIT   = 6'b000010,
    ST_PICK   = 6'b000100,
    ST_SETTLE = 6'b001000,
    ST_RELAX  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t            state;
  dgsp_pkg::vertex_t src_q;
  logic              src_ok;
  dgsp_pkg::dist_t   best_dist [dgsp_pkg::N_VERTICES];
  logic [dgsp_pkg::N_VERTICES-1:0] known;
  logic [dgsp_pkg::N_VERTICES-1:0] settled;
  dgsp_pkg::vertex_t scan;
  dgsp_pkg::vertex_t round;
  logic              pick_valid;
  logic              pick_known;
  dgsp_pkg::dist_t   pick_dist;
  dgsp_pkg::vertex_t pick_idx;
  dgsp_pkg::vertex_t rc;
  logic              issuing;
  logic              rd_valid;
  dgsp_pkg::vertex_t rd_idx;

  dgsp_pkg::vertex_t dist_idx;
  dgsp_pkg::dist_t   dist_rd;
  dgsp_pkg::sum_t    sum;
  dgsp_pkg::dist_t   cand;
  logic              take_pick;
  logic              relax_hit;

  assign idle  = (state == ST_IDLE);
  assign raddr = {pick_idx, rc};

  always_comb begin
    dist_idx = (state == ST_RELAX) ? rd_idx : scan;
    dist_rd  = best_dist[dist_idx];
    sum      = dgsp_pkg::sum_t'(pick_dist) + dgsp_pkg::sum_t'(rdata);
    cand     = (sum > dgsp_pkg::sum_t'(dgsp_pkg::DIST_MAX)) ? dgsp_pkg::DIST_MAX
                                                             : dgsp_pkg::dist_t'(sum);
    take_pick = !settled[scan] &&
                (!pick_valid ||
                 (known[scan] ? (!pick_known || dist_rd <= pick_dist) : !pick_known));
    relax_hit = !settled[rd_idx] && (rdata != '0) &&
                (!known[rd_idx] || cand < dist_rd);
  end

  always_comb begin
    res.valid       = (state == ST_EMIT);
    res.vertex_id   = dgsp_pkg::ID_BITS'(scan);
    res.path_length = known[scan] ? dist_rd : '0;
    res.reachable   = known[scan];
    res.result_last = (scan == dgsp_pkg::VERTEX_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      known      <= '0;
      settled    <= '0;
      pick_valid <= 1'b0;
      issuing    <= 1'b0;
      rd_valid   <= 1'b0;
      scan       <= '0;
      round      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            src_q  <= dgsp_pkg::vertex_t'(source);
            src_ok <= (int'(source) < dgsp_pkg::N_VERTICES);
            state  <= ST_INIT;
          end
        end
        ST_INIT: begin
          known   <= '0;
          settled <= '0;
          if (src_ok) begin
            known[src_q]     <= 1'b1;
            best_dist[src_q] <= '0;
          end
          round      <= '0;
          scan       <= '0;
          pick_valid <= 1'b0;
          state      <= ST_PICK;
        end
        ST_PICK: begin
          if (take_pick) begin
            pick_valid <= 1'b1;
            pick_known <= known[scan];
            pick_dist  <= dist_rd;
            pick_idx   <= scan;
          end
          if (scan == dgsp_pkg::VERTEX_LAST) begin
            state <= ST_SETTLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_SETTLE: begin
          scan <= '0;
          if (!pick_valid) begin
            state <= ST_EMIT;
          end else begin
            settled[pick_idx] <= 1'b1;
            if (pick_known) begin
              rc       <= '0;
              issuing  <= 1'b1;
              rd_valid <= 1'b0;
              state    <= ST_RELAX;
            end else if (round == dgsp_pkg::ROUND_LAST) begin
              state <= ST_EMIT;
            end else begin
              round      <= round + 1'b1;
              pick_valid <= 1'b0;
              state      <= ST_PICK;
            end
          end
        end
        ST_RELAX: begin
          rd_valid <= issuing;
          rd_idx   <= rc;
          if (issuing) begin
            rc <= rc + 1'b1;
            if (rc == dgsp_pkg::VERTEX_LAST) begin
              issuing <= 1'b0;
            end
          end
          if (rd_valid) begin
            if (relax_hit) begin
              best_dist[rd_idx] <= cand;
              known[rd_idx]     <= 1'b1;
            end
            if (rd_idx == dgsp_pkg::VERTEX_LAST) begin
              rd_valid <= 1'b0;
              scan     <= '0;
              if (round == dgsp_pkg::ROUND_LAST) begin
                state <= ST_EMIT;
              end else begin
                round      <= round + 1'b1;
                pick_valid <= 1'b0;
                state      <= ST_PICK;
              end
            end
          end
        end
        ST_EMIT: begin
          if (res_ready) begin
            if (scan == dgsp_pkg::VERTEX_LAST) begin
              state <= ST_IDLE;
            end else begin
              scan <= scan + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DGSP_IMPLY(a_source_known, (state == ST_PICK) && src_ok, known[src_q])
  `DGSP_IMPLY(a_relax_known_pick, state == ST_RELAX, pick_valid && pick_known)
  `DGSP_NEXT(a_settle_marks, (state == ST_SETTLE) && pick_valid, settled[$past(pick_idx)])

endmodule

### design/dense_graph_shortest_paths.sv
// ---------------------------------------------------------------------------
// dense_graph_shortest_paths
// Loads adjacency-matrix entries one per cycle (weight 0 means no edge). The
// entry marked load_last starts a search from source_vertex; load is not ready
// until every result has left the core. Each search round scans all vertices
// one per cycle for the nearest unsettled one, then walks its matrix row one
// entry per cycle through the single read port and shared add/compare unit.
// Results follow in vertex order, one per cycle without back-pressure, through
// an output register.
// ---------------------------------------------------------------------------
module dense_graph_shortest_paths (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [dgsp_pkg::ID_BITS-1:0] cfg_data,
  dgsp_load_if.sink                    load,
  dgsp_result_if.source                result
);

  logic [dgsp_pkg::ID_BITS-1:0] source_vertex;
  logic                         core_idle;
  logic                         load_xfer;
  dgsp_pkg::ram_wr_t            wr;
  dgsp_pkg::addr_t              raddr;
  dgsp_pkg::weight_t            rdata;
  dgsp_pkg::result_t            res;
  logic                         res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_vertex <= '0;
    end else if (cfg_write) begin
      source_vertex <= cfg_data;
    end
  end

  assign load.ready = core_idle;
  assign load_xfer  = load.valid && load.ready;

  always_comb begin
    wr.we    = load_xfer && (int'(load.row_vertex) < dgsp_pkg::N_VERTICES) &&
               (int'(load.col_vertex) < dgsp_pkg::N_VERTICES);
    wr.waddr = {dgsp_pkg::vertex_t'(load.row_vertex),
                dgsp_pkg::vertex_t'(load.col_vertex)};
    wr.wdata = dgsp_pkg::weight_t'(load.edge_weight);
  end

  dgsp_weight_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  dgsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (load_xfer && load.load_last),
    .source    (source_vertex),
    .idle      (core_idle),
    .raddr     (raddr),
    .rdata     (rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  // hold the result until transfer
  assign res_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_ready) begin
      result.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      result.vertex_id   <= res.vertex_id;
      result.path_length <= res.path_length;
      result.reachable   <= res.reachable;
      result.result_last <= res.result_last;
    end
  end

endmodule
